// ===== rtl/core/u8tc_pkg.sv =====
// ----------------------------------------------------------------------------
// u8tc_pkg
// Shared types, constants and encode helpers of the UTF-8 validating transcoder.
// ----------------------------------------------------------------------------
package u8tc_pkg;

  localparam logic [20:0] REPL_CP  = 21'h00FFFD;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] SUPP_MIN = 21'h010000;

  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic CFG_OUT_FORMAT = 1'b0;
  localparam logic CFG_CASE_MODE  = 1'b1;

  typedef enum logic [1:0] {
    FMT_UTF8  = 2'd0,
    FMT_UTF16 = 2'd1,
    FMT_UTF32 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    CASE_NONE  = 2'd0,
    CASE_UPPER = 2'd1,
    CASE_LOWER = 2'd2
  } case_e;

  // one decoded byte: rep_cnt replacement chars, then an optional code point
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic        has_cp;
    logic [20:0] cp;
  } cmd_t;

  function automatic logic [20:0] case_map(input logic [20:0] cp, input logic [1:0] mode);
    logic [20:0] res;
    res = cp;
    if (mode == CASE_UPPER) begin
      if ((cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'hE0 && cp <= 21'hF6) ||
          (cp >= 21'hF8 && cp <= 21'hFE)) begin
        res = cp - 21'h20;
      end
    end else if (mode == CASE_LOWER) begin
      if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'hC0 && cp <= 21'hD6) ||
          (cp >= 21'hD8 && cp <= 21'hDE)) begin
        res = cp + 21'h20;
      end
    end
    return res;
  endfunction

  // index of the last unit that encodes cp
  function automatic logic [1:0] enc_last(input logic [20:0] cp, input logic [1:0] fmt);
    logic [1:0] res;
    res = 2'd0;
    if (fmt == FMT_UTF8) begin
      if (cp <= 21'h7F) begin
        res = 2'd0;
      end else if (cp <= 21'h7FF) begin
        res = 2'd1;
      end else if (cp <= 21'hFFFF) begin
        res = 2'd2;
      end else begin
        res = 2'd3;
      end
    end else if (fmt == FMT_UTF16) begin
      res = (cp <= 21'hFFFF) ? 2'd0 : 2'd1;
    end
    return res;
  endfunction

  function automatic logic [20:0] enc_unit(input logic [20:0] cp, input logic [1:0] fmt,
                                           input logic [1:0] idx);
    logic [20:0] res;
    logic [20:0] v;
    logic [1:0]  last;
    v    = cp - SUPP_MIN;
    last = enc_last(cp, fmt);
    res  = cp;
    if (fmt == FMT_UTF8) begin
      if (idx == last) begin
        res = (last == 2'd0) ? cp : {13'd0, 2'b10, cp[5:0]};
      end else if (idx == last - 2'd1) begin
        res = (last == 2'd1) ? {13'd0, 3'b110, cp[10:6]} : {13'd0, 2'b10, cp[11:6]};
      end else if (idx == last - 2'd2) begin
        res = (last == 2'd2) ? {13'd0, 4'b1110, cp[15:12]} : {13'd0, 2'b10, cp[17:12]};
      end else begin
        res = {13'd0, 5'b11110, cp[20:18]};
      end
    end else if (fmt == FMT_UTF16) begin
      if (last == 2'd0) begin
        res = cp;
      end else if (idx == 2'd0) begin
        res = 21'hD800 + {11'd0, v[19:10]};
      end else begin
        res = 21'hDC00 + {11'd0, v[9:0]};
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/utf8_validating_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_validating_transcoder_top
// UTF-8 validating decoder with Latin-1 case map and UTF-8/16/32 re-encoding.
// ----------------------------------------------------------------------------
// The input side takes one byte per cycle while the command queue has room.
// Each accepted byte yields at most one command of up to four code points,
// and the serializer sends one output unit per cycle while out_stall_i is
// low, so one byte can yield up to twelve units (a burst of replacement
// chars in UTF-8 output). The QUEUE_DEPTH entry queue absorbs such bursts;
// sustained throughput is one unit per cycle without output stalls, set by
// the single serializer output port.
module utf8_validating_transcoder_top
  import u8tc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] unit_o,
  output logic        run_last_o
);

  logic [1:0] out_format_q;
  logic [1:0] case_mode_q;

  logic push;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic pop;
  logic q_empty;
  logic q_full;
  logic front_pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_format_q <= FMT_UTF8;
      case_mode_q  <= CASE_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUT_FORMAT: out_format_q <= cfg_wdata_i;
        CFG_CASE_MODE:  case_mode_q  <= cfg_wdata_i;
        default:        out_format_q <= out_format_q;
      endcase
    end
  end

  u8tc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .byte_i    (in_byte_i),
    .eot_i     (end_of_text_i),
    .full_i    (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .pending_o (front_pending)
  );

  u8tc_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  u8tc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_i       (out_format_q),
    .case_i      (case_mode_q),
    .cmd_i       (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .unit_o      (unit_o),
    .run_last_o  (run_last_o)
  );

  assign in_stall_o = q_full;

  // a unit is never beyond the code space, whatever the format
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_o <= MAX_CP)
    else $error("output unit beyond code space");

  // end of text leaves no sequence pending
  a_eot_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_text_i |=> !front_pending)
    else $error("pending bytes survived end of text");

  // an accepted ascii byte with nothing pending always yields a command
  a_ascii_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_byte_i[7] && !front_pending |-> push)
    else $error("ascii byte dropped");

endmodule

// ===== rtl/core/u8tc_front.sv =====
// ----------------------------------------------------------------------------
// u8tc_front
// Byte decoder: tracks the pending sequence and turns bytes into commands.
// ----------------------------------------------------------------------------
module u8tc_front
  import u8tc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  output logic       pending_o
);

  logic [2:0]  seq_width_q, seq_width_d;
  logic [1:0]  held_q, held_d;
  logic [20:0] acc_q, acc_d;

  logic        accept;
  logic        is_cont;
  logic [2:0]  held_inc;
  logic [20:0] acc_sh;
  logic [20:0] min_cp;
  cmd_t        cmd;

  assign accept   = valid_i && !full_i;
  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign held_inc = {1'b0, held_q} + 3'd1;
  assign acc_sh   = {acc_q[14:0], byte_i[5:0]};

  always_comb begin
    priority case (seq_width_q)
      3'd2:    min_cp = 21'h80;
      3'd3:    min_cp = 21'h800;
      default: min_cp = SUPP_MIN;
    endcase
  end

  always_comb begin
    cmd         = '0;
    seq_width_d = seq_width_q;
    held_d      = held_q;
    acc_d       = acc_q;
    if (seq_width_q != 3'd0 && is_cont) begin
      if (held_inc >= seq_width_q) begin
        seq_width_d = 3'd0;
        held_d      = 2'd0;
        acc_d       = '0;
        if (acc_sh < min_cp || acc_sh > MAX_CP || (acc_sh >= SURR_LO && acc_sh <= SURR_HI)) begin
          cmd.rep_cnt = held_inc;
        end else begin
          cmd.has_cp = 1'b1;
          cmd.cp     = acc_sh;
        end
      end else begin
        held_d = held_inc[1:0];
        acc_d  = acc_sh;
      end
    end else begin
      // broken sequence flushes, then the byte retries as a lead
      cmd.rep_cnt = (seq_width_q != 3'd0) ? {1'b0, held_q} : 3'd0;
      seq_width_d = 3'd0;
      held_d      = 2'd0;
      acc_d       = '0;
      if (!byte_i[7]) begin
        cmd.has_cp = 1'b1;
        cmd.cp     = {13'd0, byte_i};
      end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
        seq_width_d = 3'd2;
        held_d      = 2'd1;
        acc_d       = {16'd0, byte_i[4:0]};
      end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
        seq_width_d = 3'd3;
        held_d      = 2'd1;
        acc_d       = {17'd0, byte_i[3:0]};
      end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
        seq_width_d = 3'd4;
        held_d      = 2'd1;
        acc_d       = {18'd0, byte_i[2:0]};
      end else begin
        cmd.has_cp = 1'b1;
        cmd.cp     = REPL_CP;
      end
    end
    if (eot_i && seq_width_d != 3'd0) begin
      cmd.rep_cnt = cmd.rep_cnt + {1'b0, held_d};
      seq_width_d = 3'd0;
      held_d      = 2'd0;
      acc_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_width_q <= 3'd0;
      held_q      <= 2'd0;
      acc_q       <= '0;
    end else if (accept) begin
      seq_width_q <= seq_width_d;
      held_q      <= held_d;
      acc_q       <= acc_d;
    end
  end

  assign push_o    = accept && (cmd.rep_cnt != 3'd0 || cmd.has_cp);
  assign cmd_o     = cmd;
  assign pending_o = (seq_width_q != 3'd0);

endmodule

// ===== rtl/core/u8tc_fifo.sv =====
// ----------------------------------------------------------------------------
// u8tc_fifo
// Small command queue between the decoder and the unit serializer.
// ----------------------------------------------------------------------------
module u8tc_fifo
  import u8tc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FULL_CNT);

endmodule

// ===== rtl/core/u8tc_back.sv =====
// ----------------------------------------------------------------------------
// u8tc_back
// Unit serializer: case maps and encodes one output unit per cycle while not stalled.
// ----------------------------------------------------------------------------
module u8tc_back
  import u8tc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  fmt_i,
  input  logic [1:0]  case_i,
  input  cmd_t        cmd_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] unit_o,
  output logic        run_last_o
);

  logic        busy_q, busy_d;
  logic [2:0]  rep_q, rep_d;
  logic        has_cp_q, has_cp_d;
  logic [20:0] cp_q, cp_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q;
  logic [20:0] unit_q;
  logic        run_last_q;

  logic        advance;
  logic [20:0] cur_cp;
  logic [20:0] mapped;
  logic        last_of_cp;
  logic        last_of_item;
  logic        load;

  assign advance      = busy_q && (!out_valid_q || !out_stall_i);
  assign cur_cp       = (rep_q != 3'd0) ? REPL_CP : cp_q;
  assign mapped       = case_map(cur_cp, case_i);
  assign last_of_cp   = (idx_q == enc_last(mapped, fmt_i));
  assign last_of_item = last_of_cp &&
                        ((rep_q == 3'd0) || (rep_q == 3'd1 && !has_cp_q));
  assign load         = !empty_i && (!busy_q || (advance && last_of_item));
  assign pop_o        = load;

  always_comb begin
    busy_d   = busy_q;
    rep_d    = rep_q;
    has_cp_d = has_cp_q;
    cp_d     = cp_q;
    idx_d    = idx_q;
    if (advance) begin
      if (!last_of_cp) begin
        idx_d = idx_q + 2'd1;
      end else begin
        idx_d = 2'd0;
        if (rep_q != 3'd0) begin
          rep_d = rep_q - 3'd1;
        end else begin
          has_cp_d = 1'b0;
        end
        if (last_of_item) begin
          busy_d = 1'b0;
        end
      end
    end
    if (load) begin
      busy_d   = 1'b1;
      rep_d    = cmd_i.rep_cnt;
      has_cp_d = cmd_i.has_cp;
      cp_d     = cmd_i.cp;
      idx_d    = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rep_q       <= 3'd0;
      has_cp_q    <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      rep_q    <= rep_d;
      has_cp_q <= has_cp_d;
      idx_q    <= idx_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
    if (advance) begin
      unit_q     <= enc_unit(mapped, fmt_i, idx_q);
      run_last_q <= last_of_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign unit_o      = unit_q;
  assign run_last_o  = run_last_q;

endmodule
